>>> rtl/core/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)

`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

>>> rtl/core/hdlcrx_pkg.sv
package hdlcrx_pkg;

    localparam logic [7:0] FLAG_BYTE      = 8'h7E;
    localparam logic [7:0] ESC_DATA       = 8'h7D;
    localparam logic [2:0] STUFF_ONES     = 3'd5;
    localparam logic [2:0] DROP_ONES      = 3'd6;
    localparam logic [2:0] MAX_ONES       = 3'd7;
    localparam logic [3:0] BITS_PER_BYTE  = 4'd8;
    localparam logic [3:0] FLAG_STUFF_POS = 4'd6;
    localparam logic [3:0] NO_STUFF       = 4'd15;

    localparam int unsigned MAX_RESULTS = 3;

    localparam logic [1:0] CFG_ESC_CODE = 2'd0;
    localparam logic [1:0] CFG_ESC_7D   = 2'd1;
    localparam logic [1:0] CFG_ESC_7E   = 2'd2;

    typedef struct packed {
        logic       synced;
        logic [7:0] shift_byte;
        logic [3:0] bit_count;
        logic [2:0] ones_run;
        logic [3:0] stuffed_position;
        logic       message_open;
    } t_state;

    typedef struct packed {
        logic [7:0] escape_code;
        logic [7:0] escape_for_7d;
        logic [7:0] escape_for_7e;
    } t_cfg;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       sync_dropped;
        logic       last_of_run;
    } t_result;

endpackage

>>> rtl/core/hdlcrx_step.sv
module hdlcrx_step
    import hdlcrx_pkg::*;
(
    input  t_state        i_state,
    input  logic          i_bit,
    input  t_cfg          i_cfg,
    output t_state        o_state,
    output t_result [2:0] o_res,
    output logic    [1:0] o_count
);

    always_comb begin
        t_state        s;
        t_result [2:0] res;
        logic    [1:0] n;
        logic    [7:0] b;
        logic          do_drop;

        s       = i_state;
        res     = '0;
        n       = 2'd0;
        do_drop = 1'b0;
        s.shift_byte = {i_bit, i_state.shift_byte[7:1]};
        b = s.shift_byte;

        if (!i_state.synced) begin
            if (s.shift_byte == FLAG_BYTE) begin
                s.synced     = 1'b1;
                s.shift_byte = 8'd0;
                s.bit_count  = 4'd0;
            end
        end else if (i_state.ones_run == STUFF_ONES && !i_bit) begin
            s.stuffed_position = i_state.bit_count;
            s.ones_run         = 3'd0;
            s.shift_byte       = {s.shift_byte[6:0], 1'b0};
        end else if (i_state.ones_run == DROP_ONES && i_bit) begin
            do_drop = 1'b1;
        end else begin
            if (i_bit) begin
                if (i_state.ones_run != MAX_ONES) begin
                    s.ones_run = i_state.ones_run + 3'd1;
                end
            end else begin
                s.ones_run = 3'd0;
            end
            s.bit_count = i_state.bit_count + 4'd1;
            if (s.bit_count == BITS_PER_BYTE) begin
                if (b == FLAG_BYTE) begin
                    if (i_state.message_open) begin
                        if (i_state.stuffed_position == FLAG_STUFF_POS) begin
                            res[0] = '{i_cfg.escape_code, 1'b0, 1'b0};
                            res[1] = '{i_cfg.escape_for_7e, 1'b0, 1'b0};
                            n      = 2'd2;
                        end else begin
                            s.message_open = 1'b0;
                            res[0] = '{FLAG_BYTE, 1'b0, 1'b0};
                            n      = 2'd1;
                        end
                    end
                end else begin
                    if (!i_state.message_open) begin
                        s.message_open = 1'b1;
                        res[n] = '{FLAG_BYTE, 1'b0, 1'b0};
                        n      = n + 2'd1;
                    end
                    if (b == ESC_DATA) begin
                        res[n] = '{i_cfg.escape_code, 1'b0, 1'b0};
                        n      = n + 2'd1;
                        res[n] = '{i_cfg.escape_for_7d, 1'b0, 1'b0};
                        n      = n + 2'd1;
                    end else begin
                        res[n] = '{b, 1'b0, 1'b0};
                        n      = n + 2'd1;
                    end
                end
                s.stuffed_position = NO_STUFF;
                s.shift_byte       = 8'd0;
                s.bit_count        = 4'd0;
            end else if (s.bit_count > BITS_PER_BYTE) begin
                do_drop = 1'b1;
            end
        end

        if (do_drop) begin
            s.shift_byte   = 8'd0;
            s.bit_count    = 4'd0;
            s.synced       = 1'b0;
            s.ones_run     = 3'd0;
            s.message_open = 1'b0;
            res[0] = '{8'd0, 1'b1, 1'b0};
            n      = 2'd1;
        end

        if (n != 2'd0) begin
            res[n - 2'd1].last_of_run = 1'b1;
        end

        o_state = s;
        o_res   = res;
        o_count = n;
    end

endmodule

>>> rtl/core/hdlc_rx_bit_deframer.sv
// Channel  | Dir | Handshake                    | Payload
// ---------+-----+------------------------------+--------------------------------------
// in       | in  | i_in_valid / o_in_stall      | i_rx_bit
// out      | out | o_out_valid / i_out_stall    | o_out_byte, o_sync_dropped, o_last_of_run
// cfg      | in  | i_cfg_wr_en                  | i_cfg_addr, i_cfg_wr_data
//
// One bit per cycle unless stalled; a bit is registered, then its 0 to 3 results enter the queue.
// The results land in an 8-entry queue drained at one result per cycle while i_out_stall is low.
// Input stalls only while the queue, after this cycle's request leaves, cannot take
// three more results per bit in flight.
// Synchronous active-low reset resets deframer state and queue, and loads escape registers 7D, 5D, 5E.
`include "assert_macros.svh"

module hdlc_rx_bit_deframer
    import hdlcrx_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_rx_bit,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_sync_dropped,
    output logic       o_last_of_run,
    input  logic       i_cfg_wr_en,
    input  logic [1:0] i_cfg_addr,
    input  logic [7:0] i_cfg_wr_data
);

    localparam int unsigned DEPTH = 8;
    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_cfg             r_cfg;
    t_state           r_state;
    t_state           n_state;
    logic             r_in_valid;
    logic             r_in_bit;
    t_result [2:0]    n_res;
    logic    [1:0]    n_count;
    t_result          r_buf [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             in_take;
    logic             out_take;
    logic [1:0]       wr_num;
    logic [CNT_W+1:0] room_need;

    hdlcrx_step u_step (
        .i_state (r_state),
        .i_bit   (r_in_bit),
        .i_cfg   (r_cfg),
        .o_state (n_state),
        .o_res   (n_res),
        .o_count (n_count)
    );

    assign room_need  = (CNT_W + 2)'(r_count) - (CNT_W + 2)'(out_take)
                      + (r_in_valid ? (CNT_W + 2)'(MAX_RESULTS) : '0);
    assign o_in_stall = room_need > (CNT_W + 2)'(DEPTH - MAX_RESULTS);
    assign in_take    = i_in_valid && !o_in_stall;
    assign out_take   = o_out_valid && !i_out_stall;
    assign wr_num     = r_in_valid ? n_count : 2'd0;

    assign o_out_valid    = r_count != '0;
    assign o_out_byte     = r_buf[r_rd_ptr].out_byte;
    assign o_sync_dropped = r_buf[r_rd_ptr].sync_dropped;
    assign o_last_of_run  = r_buf[r_rd_ptr].last_of_run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg      <= '{8'd125, 8'd93, 8'd94};
            r_state    <= '{1'b0, 8'd0, 4'd0, 3'd0, NO_STUFF, 1'b0};
            r_in_valid <= 1'b0;
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_count    <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_addr)
                    CFG_ESC_CODE: r_cfg.escape_code   <= i_cfg_wr_data;
                    CFG_ESC_7D:   r_cfg.escape_for_7d <= i_cfg_wr_data;
                    CFG_ESC_7E:   r_cfg.escape_for_7e <= i_cfg_wr_data;
                    default: ;
                endcase
            end
            r_in_valid <= in_take;
            if (r_in_valid) begin
                r_state <= n_state;
            end
            r_wr_ptr <= r_wr_ptr + PTR_W'(wr_num);
            if (out_take) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_count <= r_count + CNT_W'(wr_num) - CNT_W'(out_take);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_bit <= i_rx_bit;
        end
        for (int k = 0; k < MAX_RESULTS; k++) begin
            if (2'(k) < wr_num) begin
                r_buf[r_wr_ptr + PTR_W'(k)] <= n_res[k];
            end
        end
    end

    `ASSERT_NEVER(a_queue_overflow, i_clk, i_rst_n, r_count > CNT_W'(DEPTH))
    `ASSERT_IMPLIES(a_room_for_bit, i_clk, i_rst_n, r_in_valid, r_count <= CNT_W'(DEPTH - MAX_RESULTS))
    `ASSERT_IMPLIES(a_drop_is_last, i_clk, i_rst_n, o_out_valid && o_sync_dropped, o_last_of_run && o_out_byte == 8'd0)

endmodule
